/* sv/ppf_pkg.sv */
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types, constants and helper functions of the particle pair force
// step unit.
// ----------------------------------------------------------------------------
package ppf_pkg;

  parameter int MAX_PARTICLES_DEF       = 2048;
  parameter int FORCE_TABLE_ENTRIES_DEF = 1024;

  // Interaction range in Q16.16 (256 whole units).
  parameter longint unsigned FORCE_LIM = 64'd16777216;

  parameter longint unsigned EXP_NEG1_Q32 = 64'd1580030169;
  parameter longint unsigned EXP_07_Q30   = 64'd2162250505;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  parameter logic [2:0] CFG_ARENA_W     = 3'd0;
  parameter logic [2:0] CFG_ARENA_H     = 3'd1;
  parameter logic [2:0] CFG_ACTIVE      = 3'd2;
  parameter logic [2:0] CFG_TIME_STEP   = 3'd3;
  parameter logic [2:0] CFG_DAMPING     = 3'd4;
  parameter logic [2:0] CFG_RESTITUTION = 3'd5;
  parameter logic [2:0] CFG_RADIUS      = 3'd6;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [10:0]        index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } ppf_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic               status;
  } ppf_out_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } ppf_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_READ_CAP,
    ST_REPLY,
    F_I_RD,
    F_I_CAP,
    F_M1,
    F_M2,
    F_M3,
    F_M4,
    F_M5,
    F_M6,
    F_M7,
    F_J_RD,
    F_J_CAP,
    F_J_SQX,
    F_J_SQY,
    F_J_SUM,
    F_J_SQRT,
    F_J_TAB,
    F_J_FDT,
    F_J_FDT2,
    F_J_MX,
    F_J_DX,
    F_J_DIVX,
    F_J_MY,
    F_J_DY,
    F_J_DIVY,
    F_J_UPD,
    F_I_WB
  } state_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [32:0] t;
    t = v[31] ? -{v[31], v} : {v[31], v};
    return t[31:0];
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    logic [33:0] t;
    t = v[32] ? -{v[32], v} : {v[32], v};
    return t[32:0];
  endfunction

  function automatic logic signed [34:0] apply_sign(input logic [32:0] m, input logic neg);
    logic signed [34:0] t;
    t = signed'({2'b00, m});
    return neg ? -t : t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Force sample at distance r (Q16.16), evaluated during elaboration only.
  function automatic logic signed [31:0] force_entry(input longint unsigned r);
    longint unsigned s, whole, fr, term, v, g, mag;
    longint          sum, d, q, res;
    s = (r * 64'd65536) / 64'd10;
    whole = s >> 32;
    fr = s & 64'hFFFF_FFFF;
    sum = 64'sd4294967296;
    term = 64'd4294967296;
    for (int t = 1; t <= 16; t++) begin
      term = ((term * fr) >> 32) / 64'(t);
      if (t % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    v = unsigned'(sum);
    for (int t = 0; t < 32; t++) begin
      if (64'(t) < whole) begin
        v = (v * EXP_NEG1_Q32) >> 32;
      end
    end
    g = (v * EXP_07_Q30) >> 30;
    d = signed'(r) - 64'sd458752;
    mag = (d < 0) ? unsigned'(-d) : unsigned'(d);
    q = signed'((mag * g * 64'd5 + 64'd2147483648) >> 32);
    res = (d > 0) ? -q : q;
    return res[31:0];
  endfunction

endpackage

/* sv/ppf_ram.sv */
// ----------------------------------------------------------------------------
// ppf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ppf_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ppf_sqrt.sv */
// ----------------------------------------------------------------------------
// ppf_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module ppf_sqrt #(
  parameter int IN_W = 50
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   value,
  output logic              done,
  output logic [IN_W/2-1:0] root
);

  logic [IN_W-1:0] rem;
  logic [IN_W-1:0] res;
  logic [IN_W-1:0] bitv;
  logic            active;
  logic [IN_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[IN_W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && bitv[0]) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= value;
      res  <= '0;
      bitv <= IN_W'(1) << (IN_W - 2);
    end else if (active) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

/* sv/ppf_div.sv */
// ----------------------------------------------------------------------------
// ppf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppf_div #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt;
  logic             active;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], quo[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && cnt == CW'(NUM_W - 1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
      cnt   <= '0;
    end else if (active) begin
      if (trial >= {1'b0, den_q}) begin
        rem <= trial - {1'b0, den_q};
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

endmodule

/* sv/particle_pair_force_step_unit.sv */
// ----------------------------------------------------------------------------
// particle_pair_force_step_unit
// 2D particle store with a frame step that applies pairwise forces.
// ----------------------------------------------------------------------------
// One word is taken when start is high and busy is low; busy stays high until
// the reply, which is shown on result for exactly one cycle with done high and
// cannot be held off. A pair is skipped after the offset check when an offset
// is beyond interaction range, and after the square root when the distance
// reaches the range. The in-range pair cost is set by the shared 32x32
// multiplier, the two-bits-per-cycle square root and the bit-serial divider,
// which runs twice per pair unless the particles coincide. The particle
// memory has no clearing pass: entries read before being loaded return
// unknown data.
module particle_pair_force_step_unit #(
  parameter int MAX_PARTICLES       = ppf_pkg::MAX_PARTICLES_DEF,
  parameter int FORCE_TABLE_ENTRIES = ppf_pkg::FORCE_TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ppf_pkg::ppf_in_t  item,
  output logic              done,
  output ppf_pkg::ppf_out_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [20:0]       cfg_data
);

  import ppf_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int TAB_W = $clog2(FORCE_TABLE_ENTRIES);

  // Configuration registers.
  logic [14:0] arena_width;
  logic [14:0] arena_height;
  logic [11:0] active_count;
  logic [16:0] time_step;
  logic [16:0] damping;
  logic [16:0] restitution;
  logic [20:0] radius;

  state_t state, state_next;

  logic [IDX_W-1:0] idx_addr;
  ppf_word_t        ld_word;
  logic             bad;
  logic             item_bad;

  logic [CNT_W-1:0] i_cnt, j_cnt, n_lim;

  logic signed [31:0] pxi, pyi, vxi, vyi;
  logic signed [34:0] xw, yw;
  logic               xwall, ywall;
  ppf_word_t          jw;
  logic signed [32:0] dx, dy;
  logic [32:0]        dx_mag, dy_mag;
  logic [49:0]        sq;
  logic [24:0]        r;
  logic signed [31:0] f;
  logic [31:0]        fdt_mag;
  logic               fdt_neg;
  logic signed [34:0] cx, cy;
  logic               out_of_range;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  ppf_word_t        ram_wdata;
  logic [127:0]     ram_rdata;
  ppf_word_t        rd_word;

  logic        sqrt_start, sqrt_done;
  logic [49:0] sqrt_in;
  logic [24:0] sqrt_root;

  logic        div_start, div_done;
  logic [55:0] div_q;

  logic     done_set;
  ppf_out_t res_set;

  logic signed [34:0] xhi, yhi, wlo;
  logic [39:0]        tab_prod;
  logic [TAB_W-1:0]   tab_idx;
  logic signed [31:0] ftab [FORCE_TABLE_ENTRIES];

  // Force table, fixed at elaboration.
  for (genvar k = 0; k < FORCE_TABLE_ENTRIES; k++) begin : g_tab
    localparam longint unsigned RK = (64'(k) * FORCE_LIM) / FORCE_TABLE_ENTRIES;
    assign ftab[k] = force_entry(RK);
  end

  assign rd_word  = ram_rdata;
  assign busy     = (state != ST_IDLE);
  assign dx_mag   = mag33(dx);
  assign dy_mag   = mag33(dy);
  assign xhi      = signed'({4'b0, arena_width, 16'b0}) - signed'({14'b0, radius});
  assign yhi      = signed'({4'b0, arena_height, 16'b0}) - signed'({14'b0, radius});
  assign wlo      = signed'({14'b0, radius});
  assign tab_prod = 40'(r[23:0]) * 40'(FORCE_TABLE_ENTRIES);
  assign tab_idx  = tab_prod[24 +: TAB_W];
  assign n_lim    = (32'(active_count) > 32'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES)
                                                             : CNT_W'(active_count);
  assign item_bad = (item.opcode == OP_LOAD || item.opcode == OP_READ) &&
                    (32'(item.index) >= 32'(MAX_PARTICLES));
  assign out_of_range = (dx >= 33'sd16777216) || (dx <= -33'sd16777216) ||
                        (dy >= 33'sd16777216) || (dy <= -33'sd16777216);

  ppf_ram #(
    .WIDTH($bits(ppf_word_t)),
    .DEPTH(MAX_PARTICLES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ppf_sqrt #(
    .IN_W(50)
  ) u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .value(sqrt_in),
    .done (sqrt_done),
    .root (sqrt_root)
  );

  ppf_div #(
    .NUM_W(56),
    .DEN_W(25)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (mul_p[55:0]),
    .den  (r),
    .done (div_done),
    .quo  (div_q)
  );

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_width  <= 15'd1280;
      arena_height <= 15'd1061;
      active_count <= 12'd1500;
      time_step    <= 17'd6554;
      damping      <= 17'd63570;
      restitution  <= 17'd65536;
      radius       <= 21'd131072;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ARENA_W:     arena_width  <= cfg_data[14:0];
        CFG_ARENA_H:     arena_height <= cfg_data[14:0];
        CFG_ACTIVE:      active_count <= cfg_data[11:0];
        CFG_TIME_STEP:   time_step    <= cfg_data[16:0];
        CFG_DAMPING:     damping      <= cfg_data[16:0];
        CFG_RESTITUTION: restitution  <= cfg_data[16:0];
        CFG_RADIUS:      radius       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (item_bad) begin
            state_next = ST_REPLY;
          end else begin
            case (op_t'(item.opcode))
              OP_LOAD: state_next = ST_LOAD;
              OP_READ: state_next = ST_READ;
              OP_STEP: state_next = F_I_RD;
              default: state_next = ST_REPLY;
            endcase
          end
        end
      end
      ST_LOAD:     state_next = ST_IDLE;
      ST_READ:     state_next = ST_READ_CAP;
      ST_READ_CAP: state_next = ST_IDLE;
      ST_REPLY:    state_next = ST_IDLE;
      F_I_RD:      state_next = (i_cnt >= n_lim) ? ST_IDLE : F_I_CAP;
      F_I_CAP:     state_next = F_M1;
      F_M1:        state_next = F_M2;
      F_M2:        state_next = F_M3;
      F_M3:        state_next = F_M4;
      F_M4:        state_next = F_M5;
      F_M5:        state_next = F_M6;
      F_M6:        state_next = F_M7;
      F_M7:        state_next = F_J_RD;
      F_J_RD:      state_next = (j_cnt >= n_lim) ? F_I_WB : F_J_CAP;
      F_J_CAP:     state_next = F_J_SQX;
      F_J_SQX:     state_next = out_of_range ? F_J_RD : F_J_SQY;
      F_J_SQY:     state_next = F_J_SUM;
      F_J_SUM:     state_next = F_J_SQRT;
      F_J_SQRT:    state_next = sqrt_done ? F_J_TAB : F_J_SQRT;
      F_J_TAB:     state_next = r[24] ? F_J_RD : F_J_FDT;
      F_J_FDT:     state_next = F_J_FDT2;
      F_J_FDT2:    state_next = (r == '0) ? F_J_UPD : F_J_MX;
      F_J_MX:      state_next = F_J_DX;
      F_J_DX:      state_next = F_J_DIVX;
      F_J_DIVX:    state_next = div_done ? F_J_MY : F_J_DIVX;
      F_J_MY:      state_next = F_J_DY;
      F_J_DY:      state_next = F_J_DIVY;
      F_J_DIVY:    state_next = div_done ? F_J_UPD : F_J_DIVY;
      F_J_UPD:     state_next = F_J_RD;
      F_I_WB:      state_next = F_I_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = idx_addr;
    ram_wdata  = ld_word;
    ram_raddr  = idx_addr;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    sqrt_in    = sq + mul_p[49:0];
    div_start  = 1'b0;
    done_set   = 1'b0;
    res_set    = '0;
    case (state)
      ST_LOAD: begin
        ram_we   = 1'b1;
        done_set = 1'b1;
      end
      ST_READ_CAP: begin
        done_set          = 1'b1;
        res_set.pos_x_out = rd_word.px;
        res_set.pos_y_out = rd_word.py;
        res_set.vel_x_out = rd_word.vx;
        res_set.vel_y_out = rd_word.vy;
      end
      ST_REPLY: begin
        done_set       = 1'b1;
        res_set.status = bad;
      end
      F_I_RD: begin
        ram_raddr = i_cnt[IDX_W-1:0];
        done_set  = (i_cnt >= n_lim);
      end
      F_M1: begin
        mul_a = mag32(vxi);
        mul_b = 32'(time_step);
      end
      F_M2: begin
        mul_a = mag32(vyi);
        mul_b = 32'(time_step);
      end
      F_M3: begin
        mul_a = mag32(vxi);
        mul_b = 32'(damping);
      end
      F_M4: begin
        mul_a = mag32(vyi);
        mul_b = 32'(damping);
      end
      F_M5: begin
        mul_a = mag32(vxi);
        mul_b = 32'(restitution);
      end
      F_M6: begin
        mul_a = mag32(vyi);
        mul_b = 32'(restitution);
      end
      F_J_RD: ram_raddr = j_cnt[IDX_W-1:0];
      F_J_SQX: begin
        mul_a = dx_mag[31:0];
        mul_b = dx_mag[31:0];
      end
      F_J_SQY: begin
        mul_a = dy_mag[31:0];
        mul_b = dy_mag[31:0];
      end
      F_J_SUM: sqrt_start = 1'b1;
      F_J_FDT: begin
        mul_a = mag32(f);
        mul_b = 32'(time_step);
      end
      F_J_MX: begin
        mul_a = fdt_mag;
        mul_b = dx_mag[31:0];
      end
      F_J_DX: div_start = 1'b1;
      F_J_MY: begin
        mul_a = fdt_mag;
        mul_b = dy_mag[31:0];
      end
      F_J_DY: div_start = 1'b1;
      F_J_UPD: begin
        ram_we       = 1'b1;
        ram_waddr    = j_cnt[IDX_W-1:0];
        ram_wdata.px = jw.px;
        ram_wdata.py = jw.py;
        ram_wdata.vx = sat32(35'(jw.vx) - cx);
        ram_wdata.vy = sat32(35'(jw.vy) - cy);
      end
      F_I_WB: begin
        ram_we       = 1'b1;
        ram_waddr    = i_cnt[IDX_W-1:0];
        ram_wdata.px = xw[31:0];
        ram_wdata.py = yw[31:0];
        ram_wdata.vx = vxi;
        ram_wdata.vy = vyi;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_set;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_set;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mul_p <= 64'(mul_a) * 64'(mul_b);
    case (state)
      ST_IDLE: begin
        if (start) begin
          idx_addr   <= IDX_W'(item.index);
          ld_word.px <= item.pos_x;
          ld_word.py <= item.pos_y;
          ld_word.vx <= item.vel_x;
          ld_word.vy <= item.vel_y;
          bad        <= item_bad;
          i_cnt      <= '0;
        end
      end
      F_I_CAP: begin
        pxi <= rd_word.px;
        pyi <= rd_word.py;
        vxi <= rd_word.vx;
        vyi <= rd_word.vy;
      end
      F_M2: xw <= 35'(sat32(35'(pxi) + apply_sign({1'b0, mul_p[47:16]}, vxi[31])));
      F_M3: yw <= 35'(sat32(35'(pyi) + apply_sign({1'b0, mul_p[47:16]}, vyi[31])));
      F_M4: vxi <= sat32(apply_sign({1'b0, mul_p[47:16]}, vxi[31]));
      F_M5: begin
        vyi <= sat32(apply_sign({1'b0, mul_p[47:16]}, vyi[31]));
        // The upper wall wins when the radius passes mid-arena.
        if (xw > xhi) begin
          xw    <= xhi;
          xwall <= 1'b1;
        end else if (xw < wlo) begin
          xw    <= wlo;
          xwall <= 1'b1;
        end else begin
          xwall <= 1'b0;
        end
      end
      F_M6: begin
        if (xwall) begin
          vxi <= sat32(apply_sign({1'b0, mul_p[47:16]}, !vxi[31]));
        end
        if (yw > yhi) begin
          yw    <= yhi;
          ywall <= 1'b1;
        end else if (yw < wlo) begin
          yw    <= wlo;
          ywall <= 1'b1;
        end else begin
          ywall <= 1'b0;
        end
      end
      F_M7: begin
        if (ywall) begin
          vyi <= sat32(apply_sign({1'b0, mul_p[47:16]}, !vyi[31]));
        end
        j_cnt <= i_cnt + 1'b1;
      end
      F_J_CAP: begin
        jw <= rd_word;
        dx <= 33'(signed'(xw[31:0])) - 33'(rd_word.px);
        dy <= 33'(signed'(yw[31:0])) - 33'(rd_word.py);
      end
      F_J_SQX: begin
        if (out_of_range) begin
          j_cnt <= j_cnt + 1'b1;
        end
      end
      F_J_SQY: sq <= mul_p[49:0];
      F_J_SQRT: begin
        if (sqrt_done) begin
          r <= sqrt_root;
        end
      end
      F_J_TAB: begin
        f <= ftab[tab_idx];
        if (r[24]) begin
          j_cnt <= j_cnt + 1'b1;
        end
      end
      F_J_FDT2: begin
        fdt_mag <= mul_p[47:16];
        fdt_neg <= f[31];
        // Coincident particles push the whole force along +x.
        cx <= apply_sign({1'b0, mul_p[47:16]}, f[31]);
        cy <= '0;
      end
      F_J_DIVX: begin
        if (div_done) begin
          cx <= apply_sign(div_q[32:0], fdt_neg ^ dx[32]);
        end
      end
      F_J_DIVY: begin
        if (div_done) begin
          cy <= apply_sign(div_q[32:0], fdt_neg ^ dy[32]);
        end
      end
      F_J_UPD: begin
        vxi   <= sat32(35'(vxi) + cx);
        vyi   <= sat32(35'(vyi) + cy);
        j_cnt <= j_cnt + 1'b1;
      end
      F_I_WB: i_cnt <= i_cnt + 1'b1;
      default: ;
    endcase
  end

  a_done_on_finish: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state_next == ST_IDLE) |=> done)
    else $error("work finished without a reply");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("reply without a preceding operation");

  a_write_only_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy)
    else $error("memory written while idle");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (state == F_J_CAP) |-> (j_cnt > i_cnt))
    else $error("pair partner not above the moving particle");

endmodule
